// ===== src/cdon_pkg.sv =====
// ----------------------------------------------------------------------------
// cdon_pkg
// Shared types, codes and constants of the calendar date offset normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cdon_pkg;

    // Field widths of the transfer payloads
    localparam int OpcodeW  = 2;
    localparam int YearInW  = 15;
    localparam int MonthInW = 12;
    localparam int DayInW   = 16;
    localparam int DayW     = 5;
    localparam int MonthW   = 4;
    localparam int YearW    = 14;
    localparam int CmpW     = 2;

    // Working widths
    localparam int WorkW    = 17;   // signed day and year while normalizing
    localparam int MonAccW  = 13;   // biased month sum, always positive
    localparam int MonQW    = 9;    // biased month quotient
    localparam int Y400QW   = 6;    // year / 400
    localparam int Y400RW   = 9;    // year mod 400

    // Month carry: (m - 1) is biased by 171 * 12 so floor division by 12
    // works on a positive value; the quotient bias is removed afterwards.
    localparam int MonthBias  = 2051;
    localparam int MonthQBias = 171;
    localparam int MonthsYear = 12;
    localparam int MonthRecip = 5462;   // ceil(2^16 / 12)
    localparam int MonthShift = 16;
    localparam int MonthProdW = 27;

    // Year mod 400 through a reciprocal multiply
    localparam int YearsCycle = 400;
    localparam int YearRecip  = 20972;  // ceil(2^23 / 400)
    localparam int YearShift  = 23;
    localparam int YearProdW  = 29;

    typedef enum logic [OpcodeW-1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_CMP  = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [CmpW-1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } cmp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_month;
        logic fix_month;
        logic mul_year;
        logic fix_year;
        logic walk;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;     // normalization complete or saturated
        logic bypass;   // incoming opcode leaves the date alone
    } dp_stat_t;

    // Leap year from year mod 400
    function automatic logic is_leap(input logic [Y400RW-1:0] r400);
        logic century;
        century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
        return (r400[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mon,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (mon)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== src/cdon_in_if.sv =====
// ----------------------------------------------------------------------------
// cdon_in_if
// Command channel: opcode and three signed date values with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdon_in_if
    import cdon_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [OpcodeW-1:0]          opcode;
    logic signed [YearInW-1:0]   year_value;
    logic signed [MonthInW-1:0]  month_value;
    logic signed [DayInW-1:0]    day_value;

    modport source (output valid, opcode, year_value, month_value, day_value,
                    input ready);
    modport sink   (input valid, opcode, year_value, month_value, day_value,
                    output ready);
endinterface

`default_nettype wire

// ===== src/cdon_out_if.sv =====
// ----------------------------------------------------------------------------
// cdon_out_if
// Result channel: stored date, compare result and range flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdon_out_if
    import cdon_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DayW-1:0]     day_out;
    logic [MonthW-1:0]   month_out;
    logic [YearW-1:0]    year_out;
    logic [CmpW-1:0]     compare_result;
    logic                range_error;

    modport source (output valid, day_out, month_out, year_out, compare_result,
                    range_error, input ready);
    modport sink   (input valid, day_out, month_out, year_out, compare_result,
                    range_error, output ready);
endinterface

`default_nettype wire

// ===== src/cdon_dp.sv =====
// ----------------------------------------------------------------------------
// cdon_dp
// Datapath: stored date, month carry, year mod 400 and month-by-month day walk.
// ----------------------------------------------------------------------------
`default_nettype none

module cdon_dp
    import cdon_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  wire [OpcodeW-1:0]           opcode,
    input  wire signed [YearInW-1:0]    year_value,
    input  wire signed [MonthInW-1:0]   month_value,
    input  wire signed [DayInW-1:0]     day_value,
    output logic [DayW-1:0]             day_out,
    output logic [MonthW-1:0]           month_out,
    output logic [YearW-1:0]            year_out,
    output logic [CmpW-1:0]             compare_result,
    output logic                        range_error
);

    localparam logic signed [WorkW-1:0] MaxYearS = WorkW'(MAX_YEAR);
    localparam logic signed [WorkW-1:0] OneS     = WorkW'(1);

    // Stored date
    logic [DayW-1:0]    cur_day_reg,   cur_day_next;
    logic [MonthW-1:0]  cur_month_reg, cur_month_next;
    logic [YearW-1:0]   cur_year_reg,  cur_year_next;

    // Working date
    logic [OpcodeW-1:0]        op_reg,    op_next;
    logic [MonAccW-1:0]        macc_reg,  macc_next;
    logic [MonQW-1:0]          mq_reg,    mq_next;
    logic [Y400QW-1:0]         yq_reg,    yq_next;
    logic [Y400RW-1:0]         r400_reg,  r400_next;
    logic signed [WorkW-1:0]   day_reg,   day_next;
    logic signed [WorkW-1:0]   year_reg,  year_next;
    logic [MonthW-1:0]         mon_reg,   mon_next;
    logic                      err_reg,   err_next;
    logic                      done_reg,  done_next;

    // Result payload
    logic [DayW-1:0]    rday_reg,  rday_next;
    logic [MonthW-1:0]  rmon_reg,  rmon_next;
    logic [YearW-1:0]   ryear_reg, ryear_next;
    logic [CmpW-1:0]    rcmp_reg,  rcmp_next;
    logic               rerr_reg,  rerr_next;

    logic                      add_sel;
    logic signed [MonAccW:0]   msum;
    logic [MonthProdW-1:0]     mprod;
    logic [MonAccW-1:0]        mrem;
    logic [YearProdW-1:0]      yprod;
    logic [YearW-1:0]          ydiff;
    logic                      leap;
    logic [DayW-1:0]           len_cur;
    logic [DayW-1:0]           len_prev;
    logic [MonthW-1:0]         mon_prev;
    logic signed [WorkW-1:0]   len_cur_s;
    logic [DayW+MonthW+YearW-1:0] key_cur;
    logic [DayW+MonthW+YearW-1:0] key_new;

    assign add_sel = (opcode_t'(opcode) == OP_ADD);
    assign msum    = (MonAccW+1)'(month_value)
                   + (add_sel ? $signed({(MonAccW+1-MonthW)'(0), cur_month_reg})
                              : (MonAccW+1)'(0))
                   + (MonAccW+1)'(MonthBias);
    assign mprod   = MonthProdW'(macc_reg) * MonthProdW'(MonthRecip);
    assign mrem    = macc_reg - MonAccW'(MonAccW'(mq_reg) * MonAccW'(MonthsYear));
    assign yprod   = YearProdW'(year_reg[YearW-1:0]) * YearProdW'(YearRecip);
    assign ydiff   = year_reg[YearW-1:0] - YearW'(YearW'(yq_reg) * YearW'(YearsCycle));
    assign leap    = is_leap(r400_reg);
    assign len_cur = month_len(mon_reg, leap);
    assign mon_prev = mon_reg - 4'd1;
    assign len_prev = month_len(mon_prev, leap);
    assign len_cur_s = $signed({(WorkW-DayW)'(0), len_cur});
    assign key_cur = {cur_year_reg, cur_month_reg, cur_day_reg};
    assign key_new = {year_reg[YearW-1:0], mon_reg, day_reg[DayW-1:0]};

    assign stat.done   = done_reg;
    assign stat.bypass = (opcode_t'(opcode) == OP_NONE);

    always_comb
    begin
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        op_next        = op_reg;
        macc_next      = macc_reg;
        mq_next        = mq_reg;
        yq_next        = yq_reg;
        r400_next      = r400_reg;
        day_next       = day_reg;
        year_next      = year_reg;
        mon_next       = mon_reg;
        err_next       = err_reg;
        done_next      = done_reg;
        rday_next      = rday_reg;
        rmon_next      = rmon_reg;
        ryear_next     = ryear_reg;
        rcmp_next      = rcmp_reg;
        rerr_next      = rerr_reg;

        if (cmd.load)
        begin
            op_next   = opcode;
            macc_next = msum[MonAccW-1:0];
            day_next  = WorkW'(day_value)
                      + (add_sel ? $signed({(WorkW-DayW)'(0), cur_day_reg}) : WorkW'(0));
            year_next = WorkW'(year_value)
                      + (add_sel ? $signed({(WorkW-YearW)'(0), cur_year_reg}) : WorkW'(0));
            err_next  = 1'b0;
            done_next = 1'b0;
        end

        if (cmd.mul_month)
            mq_next = mprod[MonthShift+MonQW-1:MonthShift];

        if (cmd.fix_month)
        begin
            mon_next  = mrem[MonthW-1:0] + 4'd1;
            year_next = year_reg + $signed({(WorkW-MonQW)'(0), mq_reg})
                      - WorkW'(MonthQBias);
        end

        if (cmd.mul_year)
        begin
            yq_next = yprod[YearShift+Y400QW-1:YearShift];
            if (year_reg < OneS)
            begin
                day_next = WorkW'(1); mon_next = 4'd1; year_next = OneS;
                err_next = 1'b1; done_next = 1'b1;
            end
            else if (year_reg > MaxYearS)
            begin
                day_next = WorkW'(31); mon_next = 4'd12; year_next = MaxYearS;
                err_next = 1'b1; done_next = 1'b1;
            end
        end

        if (cmd.fix_year && !done_reg)
            r400_next = ydiff[Y400RW-1:0];

        if (cmd.walk && !done_reg)
        begin
            if (day_reg > len_cur_s)
            begin
                // Advance one month forward
                day_next = day_reg - len_cur_s;
                if (mon_reg == 4'd12)
                begin
                    if (year_reg >= MaxYearS)
                    begin
                        day_next = WorkW'(31); mon_next = 4'd12; year_next = MaxYearS;
                        err_next = 1'b1; done_next = 1'b1;
                    end
                    else
                    begin
                        mon_next  = 4'd1;
                        year_next = year_reg + OneS;
                        r400_next = (r400_reg == Y400RW'(YearsCycle - 1))
                                  ? Y400RW'(0) : r400_reg + Y400RW'(1);
                    end
                end
                else
                    mon_next = mon_reg + 4'd1;
            end
            else if (day_reg <= WorkW'(0))
            begin
                // Step back one month; December always has 31 days
                if (mon_reg == 4'd1)
                begin
                    if (year_reg <= OneS)
                    begin
                        day_next = WorkW'(1); mon_next = 4'd1; year_next = OneS;
                        err_next = 1'b1; done_next = 1'b1;
                    end
                    else
                    begin
                        mon_next  = 4'd12;
                        year_next = year_reg - OneS;
                        day_next  = day_reg + WorkW'(31);
                        r400_next = (r400_reg == Y400RW'(0))
                                  ? Y400RW'(YearsCycle - 1) : r400_reg - Y400RW'(1);
                    end
                end
                else
                begin
                    mon_next = mon_prev;
                    day_next = day_reg + $signed({(WorkW-DayW)'(0), len_prev});
                end
            end
            else
                done_next = 1'b1;
        end

        if (cmd.finish)
        begin
            rday_next  = cur_day_reg;
            rmon_next  = cur_month_reg;
            ryear_next = cur_year_reg;
            rcmp_next  = CMP_LESS;
            rerr_next  = 1'b0;
            case (opcode_t'(op_reg))
                OP_LOAD, OP_ADD:
                begin
                    cur_day_next   = day_reg[DayW-1:0];
                    cur_month_next = mon_reg;
                    cur_year_next  = year_reg[YearW-1:0];
                    rday_next      = day_reg[DayW-1:0];
                    rmon_next      = mon_reg;
                    ryear_next     = year_reg[YearW-1:0];
                    rerr_next      = err_reg;
                end
                OP_CMP:
                begin
                    rerr_next = err_reg;
                    if (key_cur < key_new)
                        rcmp_next = CMP_LESS;
                    else if (key_cur == key_new)
                        rcmp_next = CMP_EQUAL;
                    else
                        rcmp_next = CMP_GREATER;
                end
                default:
                begin
                    rerr_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_day_reg   <= DayW'(1);
            cur_month_reg <= MonthW'(1);
            cur_year_reg  <= YearW'(2000);
            done_reg      <= 1'b0;
        end
        else
        begin
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        macc_reg  <= macc_next;
        mq_reg    <= mq_next;
        yq_reg    <= yq_next;
        r400_reg  <= r400_next;
        day_reg   <= day_next;
        year_reg  <= year_next;
        mon_reg   <= mon_next;
        err_reg   <= err_next;
        rday_reg  <= rday_next;
        rmon_reg  <= rmon_next;
        ryear_reg <= ryear_next;
        rcmp_reg  <= rcmp_next;
        rerr_reg  <= rerr_next;
    end

    assign day_out        = rday_reg;
    assign month_out      = rmon_reg;
    assign year_out       = ryear_reg;
    assign compare_result = rcmp_reg;
    assign range_error    = rerr_reg;

endmodule

`default_nettype wire

// ===== src/cdon_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdon_ctrl
// Sequencer: steps the datapath through month carry, year setup and day walk.
// ----------------------------------------------------------------------------
`default_nettype none

module cdon_ctrl
    import cdon_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire       out_ready,
    input  dp_stat_t  stat,
    output dp_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MDIV = 7'b0000010,
        S_MFIX = 7'b0000100,
        S_YDIV = 7'b0001000,
        S_YMOD = 7'b0010000,
        S_WALK = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        // Drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.bypass ? S_FIN : S_MDIV;
                end
            end
            S_MDIV:
            begin
                cmd.mul_month = 1'b1;
                state_next    = S_MFIX;
            end
            S_MFIX:
            begin
                cmd.fix_month = 1'b1;
                state_next    = S_YDIV;
            end
            S_YDIV:
            begin
                cmd.mul_year = 1'b1;
                state_next   = S_YMOD;
            end
            S_YMOD:
            begin
                cmd.fix_year = 1'b1;
                state_next   = stat.done ? S_FIN : S_WALK;
            end
            S_WALK:
            begin
                if (stat.done)
                    state_next = S_FIN;
                else
                    cmd.walk = 1'b1;
            end
            S_FIN:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/calendar_date_offset_normalizer.sv =====
// ----------------------------------------------------------------------------
// calendar_date_offset_normalizer
// Gregorian date register with load, add-offsets and compare operations.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: opcode (load, add, compare, or
//   the unused code, which just reports the date) and signed year, month and
//   day values. out_ch returns exactly one result per command: the stored
//   date after the operation, the compare ranking and the range flag.
//   Timing: one command at a time. A command is accepted, goes through month
//   carry and year setup (two multiplier steps), then the day walker steps one
//   month at a time, and then the result is posted. The unused opcode skips
//   from acceptance straight to posting. The day walker sets the rate.
//   The result sits in an output register; the next command is taken while
//   it still waits. If the receiver stalls, the next command finishes its
//   work and then holds until the previous result has been transferred.
//   Reset (rst_n, asynchronous, active low) sets the date to 1.1.2000 and
//   empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_offset_normalizer
    import cdon_pkg::*;
#(
    parameter int MAX_YEAR = 9999
)
(
    input  wire          clk,
    input  wire          rst_n,
    cdon_in_if.sink      in_ch,
    cdon_out_if.source   out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: at most one datapath step per cycle; stalls while output is full
    cdon_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: stored date, normalizer and result register
    cdon_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (in_ch.opcode),
        .year_value     (in_ch.year_value),
        .month_value    (in_ch.month_value),
        .day_value      (in_ch.day_value),
        .day_out        (out_ch.day_out),
        .month_out      (out_ch.month_out),
        .year_out       (out_ch.year_out),
        .compare_result (out_ch.compare_result),
        .range_error    (out_ch.range_error)
    );

    // The block is busy right after taking a command
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("command accepted while busy");

    // A posted month is always a calendar month
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.month_out >= 4'd1) && (out_ch.month_out <= 4'd12))
        else $error("month out of range");

    // A posted day is never zero
    a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.day_out != 5'd0)
        else $error("day is zero");

    // Compare result never carries the unused code
    a_cmp_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.compare_result != 2'd3)
        else $error("invalid compare code");

endmodule

`default_nettype wire

// ===== sim/calendar_date_offset_normalizer_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_date_offset_normalizer_tb
// Self-checking testbench of the Gregorian date register. A table of directed
// commands (extremes, month carry, leap years, saturation at both ends,
// compare) is followed by random load, add, compare and unused-opcode commands
// that track the stored date. Every command is scored against its hand-written
// expectation or an in-bench date model, with random idle bursts on both
// channels, one long receiver hold-off and two full drains.
// ----------------------------------------------------------------------------

module calendar_date_offset_normalizer_tb
    import cdon_pkg::*;
;

    localparam int MaxYear       = 9999;
    localparam int LimitCycles   = 3_000_000;
    localparam int HoldOffCycles = 800;
    localparam int DrainCycles   = 1200;

    // One command as offered on the input channel
    typedef struct {
        opcode_t                    op;
        logic signed [YearInW-1:0]  year_v;
        logic signed [MonthInW-1:0] month_v;
        logic signed [DayInW-1:0]   day_v;
    } date_cmd_t;

    // One result as seen on the output channel
    typedef struct packed {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic [CmpW-1:0]   cmp;
        logic              err;
    } date_result_t;

    // Directed row: command plus an optional hand-written expectation
    typedef struct {
        date_cmd_t    cmd;
        bit           typed;
        date_result_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    cdon_in_if  in_ch ();
    cdon_out_if out_ch ();

    calendar_date_offset_normalizer #(
        .MAX_YEAR (MaxYear)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Model copy of the stored date
    logic [DayW-1:0]   stored_day;
    logic [MonthW-1:0] stored_month;
    logic [YearW-1:0]  stored_year;

    date_result_t  expected_dates[$];
    directed_row_t directed_rows[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    bit          send_gaps;
    bit          take_gaps;
    bit          hold_off_req;

    // ------------------------------------------------------------------------
    // Date model
    // ------------------------------------------------------------------------

    function automatic bit leap_year(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint month_days(input longint m, input longint y);
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Carry months into years first, then walk days one month at a time.
    // Returns 1 when the year left 1..MaxYear and the date was saturated.
    function automatic bit normalize_date(inout longint d, inout longint m,
                                          inout longint y);
        longint q;
        longint r;
        bit     under_range;
        bit     over_range;
        q = (m - 1) / 12;
        r = (m - 1) % 12;
        if (r < 0)
        begin
            r += 12;
            q -= 1;
        end
        m = r + 1;
        y += q;
        under_range = (y < 1);
        over_range  = (y > MaxYear);
        if (!under_range && !over_range)
        begin
            while (!over_range && d > month_days(m, y))
            begin
                d -= month_days(m, y);
                m++;
                if (m > 12)
                begin
                    m = 1;
                    y++;
                    over_range = (y > MaxYear);
                end
            end
            while (!over_range && !under_range && d <= 0)
            begin
                m--;
                if (m < 1)
                begin
                    m = 12;
                    y--;
                    under_range = (y < 1);
                end
                if (!under_range)
                    d += month_days(m, y);
            end
        end
        if (under_range)
        begin
            d = 1;
            m = 1;
            y = 1;
        end
        else if (over_range)
        begin
            d = 31;
            m = 12;
            y = MaxYear;
        end
        return under_range || over_range;
    endfunction

    // Apply one command to the stored date and return the result it must give
    function automatic date_result_t apply_date_command(input date_cmd_t c);
        longint       d;
        longint       m;
        longint       y;
        longint       lhs;
        longint       rhs;
        date_result_t res;
        res.cmp = CMP_LESS;
        res.err = 1'b0;
        d = longint'(c.day_v);
        m = longint'(c.month_v);
        y = longint'(c.year_v);
        case (c.op)
            OP_LOAD, OP_ADD:
            begin
                if (c.op == OP_ADD)
                begin
                    d += longint'(stored_day);
                    m += longint'(stored_month);
                    y += longint'(stored_year);
                end
                res.err      = normalize_date(d, m, y);
                stored_day   = d[DayW-1:0];
                stored_month = m[MonthW-1:0];
                stored_year  = y[YearW-1:0];
            end
            OP_CMP:
            begin
                res.err = normalize_date(d, m, y);
                lhs = longint'(stored_year) * 10000 + longint'(stored_month) * 100
                    + longint'(stored_day);
                rhs = y * 10000 + m * 100 + d;
                if (lhs < rhs)
                    res.cmp = CMP_LESS;
                else if (lhs == rhs)
                    res.cmp = CMP_EQUAL;
                else
                    res.cmp = CMP_GREATER;
            end
            default: ;
        endcase
        res.day   = stored_day;
        res.month = stored_month;
        res.year  = stored_year;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_row(input opcode_t op, input int yr, input int mon, input int dy,
                           input bit typed, input int want_day, input int want_month,
                           input int want_year, input cmp_t want_cmp, input bit want_err);
        directed_row_t row;
        row.cmd.op          = op;
        row.cmd.year_v      = YearInW'(yr);
        row.cmd.month_v     = MonthInW'(mon);
        row.cmd.day_v       = DayInW'(dy);
        row.typed           = typed;
        row.want.day        = DayW'(want_day);
        row.want.month      = MonthW'(want_month);
        row.want.year       = YearW'(want_year);
        row.want.cmp        = want_cmp;
        row.want.err        = want_err;
        directed_rows.push_back(row);
    endtask

    // Mostly well-formed commands built around the current date, with a share
    // of raw noise over the whole width of every field.
    function automatic date_cmd_t draw_command();
        date_cmd_t c;
        int        pick;
        int        yr;
        int        mon;
        int        dy;
        c.op      = opcode_t'($urandom_range(0, 3));
        c.year_v  = YearInW'($urandom);
        c.month_v = MonthInW'($urandom);
        c.day_v   = DayInW'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick >= 12)
        begin
            if (pick < 45)
            begin
                c.op = OP_LOAD;
                if ($urandom_range(0, 9) == 0)
                    yr = $urandom_range(0, 1) ? 1 : MaxYear;
                else
                    yr = $urandom_range(1, MaxYear);
                if ($urandom_range(0, 4) == 0)
                    mon = int'($urandom_range(0, 40)) - 14;
                else
                    mon = $urandom_range(1, 12);
                if ($urandom_range(0, 4) == 0)
                    dy = int'($urandom_range(0, 80)) - 20;
                else
                    dy = $urandom_range(1, 31);
            end
            else if (pick < 78)
            begin
                c.op = OP_ADD;
                yr   = int'($urandom_range(0, 40)) - 20;
                mon  = int'($urandom_range(0, 60)) - 30;
                // long day walks are slow; keep them rare
                if ($urandom_range(0, 9) == 0)
                    dy = int'($urandom_range(0, 65535)) - 32768;
                else
                    dy = int'($urandom_range(0, 800)) - 400;
            end
            else if (pick < 96)
            begin
                c.op = OP_CMP;
                yr   = int'(stored_year);
                mon  = int'(stored_month);
                dy   = int'(stored_day);
                case ($urandom_range(0, 3))
                    0: ;
                    1: dy = dy + int'($urandom_range(0, 2)) - 1;
                    2: yr = yr + int'($urandom_range(0, 2)) - 1;
                    default:
                    begin
                        yr  = $urandom_range(1, MaxYear);
                        mon = $urandom_range(1, 12);
                        dy  = $urandom_range(1, 31);
                    end
                endcase
            end
            else
            begin
                c.op = OP_NONE;
                yr   = int'(c.year_v);
                mon  = int'(c.month_v);
                dy   = int'(c.day_v);
            end
            c.year_v  = YearInW'(yr);
            c.month_v = MonthInW'(mon);
            c.day_v   = DayInW'(dy);
        end
        return c;
    endfunction

    // Offer one command, hold it until the transfer, then log what it must
    // return. Called at a rising edge; valid stays high after the transfer so
    // a follow-up command can go out back to back.
    task automatic send_command(input date_cmd_t c, input bit typed,
                                input date_result_t want);
        date_result_t predicted;
        int           gap;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= c.op;
        in_ch.year_value  <= c.year_v;
        in_ch.month_value <= c.month_v;
        in_ch.day_value   <= c.day_v;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = apply_date_command(c);
        expected_dates.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every pending result has been transferred
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LimitCycles)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("calendar_date_offset_normalizer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready pattern and scoreboard
    // ------------------------------------------------------------------------

    // Drive ready: random stall bursts, or one long hold-off on request so
    // the block fills up and pushes back on its command channel.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (take_gaps && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 15);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Score every result transfer against the oldest pending expectation
    initial
    begin
        date_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (expected_dates.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no command pending, actual %0d.%0d.%0d",
                             $time, out_ch.day_out, out_ch.month_out, out_ch.year_out);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("day_out", 32'(want.day), 32'(out_ch.day_out));
                    check_field("month_out", 32'(want.month), 32'(out_ch.month_out));
                    check_field("year_out", 32'(want.year), 32'(out_ch.year_out));
                    check_field("compare_result", 32'(want.cmp),
                                32'(out_ch.compare_result));
                    check_field("range_error", 32'(want.err), 32'(out_ch.range_error));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side: directed table, random phases, pressure, drain
    // ------------------------------------------------------------------------

    initial
    begin
        stored_day     = DayW'(1);
        stored_month   = MonthW'(1);
        stored_year    = YearW'(2000);
        mismatch_count = 0;
        send_gaps      = 1'b1;
        take_gaps      = 1'b1;
        hold_off_req   = 1'b0;

        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_NONE;
        in_ch.year_value  <= '0;
        in_ch.month_value <= '0;
        in_ch.day_value   <= '0;

        // Directed table. A 1 in the fifth column means the expected date,
        // compare code and range flag that follow are checked as written;
        // the other rows are scored by the model.
        //      op       year    month   day    fix  day mon  year  cmp          err
        add_row(OP_NONE,      0,     0,      0, 1,  1,  1, 2000, CMP_LESS,    0);
        add_row(OP_CMP,    2000,     1,      1, 1,  1,  1, 2000, CMP_EQUAL,   0);
        add_row(OP_LOAD,   2024,     2,     29, 1, 29,  2, 2024, CMP_LESS,    0);
        add_row(OP_CMP,    1999,    12,     31, 1, 29,  2, 2024, CMP_GREATER, 0);
        add_row(OP_ADD,       1,     0,      0, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_LOAD, -16384, -2048, -32768, 1,  1,  1,    1, CMP_LESS,    1);
        add_row(OP_LOAD,  16383,  2047,  32767, 1, 31, 12, 9999, CMP_LESS,    1);
        add_row(OP_LOAD,      0,     1,      1, 1,  1,  1,    1, CMP_LESS,    1);
        add_row(OP_LOAD,      1,     1,      0, 1,  1,  1,    1, CMP_LESS,    1);
        add_row(OP_LOAD,   9999,    12,     31, 1, 31, 12, 9999, CMP_LESS,    0);
        add_row(OP_ADD,       0,     0,      1, 1, 31, 12, 9999, CMP_LESS,    1);
        add_row(OP_LOAD,   2000,    13,      1, 1,  1,  1, 2001, CMP_LESS,    0);
        add_row(OP_LOAD,   2000,     0,      1, 1,  1, 12, 1999, CMP_LESS,    0);
        add_row(OP_LOAD,   2000, -1200,      1, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_LOAD,   1900,     2,     29, 1,  1,  3, 1900, CMP_LESS,    0);
        add_row(OP_LOAD,   2000,     2,     30, 1,  1,  3, 2000, CMP_LESS,    0);
        add_row(OP_LOAD,   2100,     3,      0, 1, 28,  2, 2100, CMP_LESS,    0);
        add_row(OP_ADD,       0,     0,  32767, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_ADD,       0,     0, -32768, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_ADD,       0,  1200,      0, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_ADD,       0, -2048,      0, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_ADD,   -9999,     0,      0, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_CMP,       1,     1,      1, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_CMP,    9999,    12,     31, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_CMP,      -5,     1,      1, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_CMP,   16383,     1,      1, 0,  0,  0,    0, CMP_LESS,    0);
        add_row(OP_NONE,     -1,    -1,     -1, 0,  0,  0,    0, CMP_LESS,    0);

        // Hold reset, then release it once for good
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].typed,
                         directed_rows[i].want);

        // Random traffic with idle bursts on both sides
        repeat (200) send_command(draw_command(), 1'b0, '0);

        // Pause the sender until every result is back
        wait_all_results();

        // Hold the receiver off for a long stretch while commands keep
        // coming back to back; the block must fill up and stall its input
        send_gaps    = 1'b0;
        hold_off_req = 1'b1;
        repeat (12) send_command(draw_command(), 1'b0, '0);
        send_gaps = 1'b1;

        repeat (200) send_command(draw_command(), 1'b0, '0);

        // Last stretch at full rate, no idling anywhere
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        repeat (100) send_command(draw_command(), 1'b0, '0);

        // Drain, then give a stray result time to show up
        wait_all_results();
        repeat (DrainCycles) @(posedge clk);

        if (mismatch_count == 0)
            $display("calendar_date_offset_normalizer regression: pass");
        else
            $display("calendar_date_offset_normalizer regression: fail");
        $finish;
    end

endmodule
